FILE: hw/rtl/slip_rc_pkg.sv
`default_nettype none

package slip_rc_pkg;

    // Frame store capacity in decoded bytes
    localparam logic [6:0] FRAME_CAP = 7'd80;

    // Minimum lengths for classification
    localparam logic [6:0] MIN_CLASS_LEN = 7'd2;
    localparam logic [6:0] MIN_GOOD_LEN  = 7'd10;

    // SLIP special bytes
    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    // Direction bytes
    localparam logic [7:0] DIR_REQUEST = 8'h00;
    localparam logic [7:0] DIR_REPLY   = 8'h01;

    // Register reset value and address decode
    localparam logic [7:0] EXPECTED_CMD_RESET = 8'h08;
    localparam int         CFG_ADDR_W         = 3;
    localparam logic       REG_EXPECTED_CMD   = 1'b0;

    // Event codes reported in m_tuser
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_NOISE = 3'd1,
        EV_ECHO  = 3'd2,
        EV_GOOD  = 3'd3,
        EV_OTHER = 3'd4
    } ev_code_t;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 152;
    localparam int OUT_USER_W = 3;

endpackage

`default_nettype wire

FILE: hw/rtl/slip_reply_classifier_unit.sv
`default_nettype none

// SLIP deframer and reply classifier.
// Input stream: one received serial byte per beat in s_tdata, s_tuser set
// to drop any open frame and pending escape before that byte.
// Result stream: exactly one result beat per input beat, in order. m_tuser
// carries the event code, m_tdata the sticky sync flag, the four wrapping
// counters and the direction and command bytes of the last classified frame.
// Latency: the result is valid in the cycle after the input beat is taken.
// Throughput: one beat per cycle; the decode, classify and counter update
// sit between the input handshake and the single result register.
// When the receiver stalls, the result register holds and s_tready drops
// only while that register is full and not being taken.
// APB port: expected_cmd at byte addresses 0 to 3 (paddr[2] low), written in
// the access cycle, pready always high.
// Reset (synchronous, aresetn low): frame state, counters, flags and the
// result valid are cleared, expected_cmd returns to 0x08.
module slip_reply_classifier_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [slip_rc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] rx_byte
    input  wire logic [slip_rc_pkg::IN_DATA_W-1:0] s_tdata,
    // [0] new_burst
    input  wire logic        s_tuser,
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] sync_seen, [32:1] rx_total, [64:33] noise_total, [96:65] echo_total,
    // [128:97] other_total, [136:129] seen_dir, [144:137] seen_cmd, [151:145] zero
    output logic [slip_rc_pkg::OUT_DATA_W-1:0] m_tdata,
    // [2:0] event_res
    output logic [slip_rc_pkg::OUT_USER_W-1:0] m_tuser
);
    import slip_rc_pkg::*;

    logic       expected_cmd_reg;
    logic [7:0] exp_cmd_reg;

    logic       in_frame_reg,  in_frame_next;
    logic       esc_reg,       esc_next;
    logic [6:0] len_reg,       len_next;
    logic [7:0] first_reg,     first_next;
    logic [7:0] second_reg,    second_next;
    logic [7:0] prev_reg,      prev_next;
    logic [7:0] last_reg,      last_next;
    logic [31:0] rx_count_reg,    rx_count_next;
    logic [31:0] noise_count_reg, noise_count_next;
    logic [31:0] echo_count_reg,  echo_count_next;
    logic [31:0] other_count_reg, other_count_next;
    logic [7:0] dir_reg,       dir_next;
    logic [7:0] cmd_reg,       cmd_next;
    logic       sync_reg,      sync_next;
    ev_code_t   ev_next;

    logic        m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;

    logic s_acc;
    logic cfg_wr;

    // Config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign expected_cmd_reg = (paddr[CFG_ADDR_W-1] == REG_EXPECTED_CMD);
    assign prdata = expected_cmd_reg ? {24'd0, exp_cmd_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_cmd_reg <= EXPECTED_CMD_RESET;
        end else if (cfg_wr && expected_cmd_reg) begin
            exp_cmd_reg <= pwdata[7:0];
        end
    end

    // Handshake: take a beat whenever the result register frees up
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    // Decode, store and classify one byte
    always_comb begin
        logic [7:0] b;
        logic       inf;
        logic       do_store;

        b    = s_tdata;
        inf  = s_tuser ? 1'b0 : in_frame_reg;
        do_store = 1'b0;

        in_frame_next    = inf;
        esc_next         = s_tuser ? 1'b0 : esc_reg;
        len_next         = s_tuser ? 7'd0 : len_reg;
        first_next       = first_reg;
        second_next      = second_reg;
        prev_next        = prev_reg;
        last_next        = last_reg;
        rx_count_next    = rx_count_reg + 32'd1;
        noise_count_next = noise_count_reg;
        echo_count_next  = echo_count_reg;
        other_count_next = other_count_reg;
        dir_next         = dir_reg;
        cmd_next         = cmd_reg;
        sync_next        = sync_reg;
        ev_next          = EV_NONE;

        priority if (b == SLIP_END) begin
            // Close the open frame, then open a new one
            if (inf && (len_next >= MIN_CLASS_LEN)) begin
                dir_next = first_reg;
                cmd_next = second_reg;
                priority if (first_reg == DIR_REQUEST && second_reg == exp_cmd_reg) begin
                    echo_count_next = echo_count_reg + 32'd1;
                    ev_next = EV_ECHO;
                end else if (len_next >= MIN_GOOD_LEN && first_reg == DIR_REPLY &&
                             second_reg == exp_cmd_reg && prev_reg == 8'd0) begin
                    sync_next = 1'b1;
                    ev_next = EV_GOOD;
                end else begin
                    other_count_next = other_count_reg + 32'd1;
                    ev_next = EV_OTHER;
                end
            end
            in_frame_next = 1'b1;
            len_next      = 7'd0;
            esc_next      = 1'b0;
        end else if (!inf) begin
            noise_count_next = noise_count_reg + 32'd1;
            ev_next = EV_NOISE;
        end else if (esc_next) begin
            // Resolve the escaped byte
            if (b == SLIP_ESC_END) begin
                b = SLIP_END;
            end else if (b == SLIP_ESC_ESC) begin
                b = SLIP_ESC;
            end
            esc_next = 1'b0;
            do_store = 1'b1;
        end else if (b == SLIP_ESC) begin
            esc_next = 1'b1;
        end else begin
            do_store = 1'b1;
        end

        // Store a data byte unless the frame is full
        if (do_store && (len_next < FRAME_CAP)) begin
            if (len_next == 7'd0) begin
                first_next = b;
            end else if (len_next == 7'd1) begin
                second_next = b;
            end
            prev_next = last_reg;
            last_next = b;
            len_next  = len_next + 7'd1;
        end
    end

    // Advance frame state and counters on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg    <= 1'b0;
            esc_reg         <= 1'b0;
            len_reg         <= 7'd0;
            first_reg       <= 8'd0;
            second_reg      <= 8'd0;
            prev_reg        <= 8'd0;
            last_reg        <= 8'd0;
            rx_count_reg    <= 32'd0;
            noise_count_reg <= 32'd0;
            echo_count_reg  <= 32'd0;
            other_count_reg <= 32'd0;
            dir_reg         <= 8'd0;
            cmd_reg         <= 8'd0;
            sync_reg        <= 1'b0;
        end else if (s_acc) begin
            in_frame_reg    <= in_frame_next;
            esc_reg         <= esc_next;
            len_reg         <= len_next;
            first_reg       <= first_next;
            second_reg      <= second_next;
            prev_reg        <= prev_next;
            last_reg        <= last_next;
            rx_count_reg    <= rx_count_next;
            noise_count_reg <= noise_count_next;
            echo_count_reg  <= echo_count_next;
            other_count_reg <= other_count_next;
            dir_reg         <= dir_next;
            cmd_reg         <= cmd_next;
            sync_reg        <= sync_next;
        end
    end

    // Result register: load on accept, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_acc) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_tuser_reg <= ev_next;
            m_tdata_reg <= {7'd0, cmd_next, dir_next, other_count_next,
                            echo_count_next, noise_count_next, rx_count_next, sync_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> m_tvalid_reg)
        else $error("accepted beat produced no result");

    a_rx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> rx_count_reg == $past(rx_count_reg) + 32'd1)
        else $error("rx counter did not advance by one");

    a_esc_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> in_frame_reg)
        else $error("escape pending outside a frame");

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= FRAME_CAP)
        else $error("frame length beyond capacity");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_acc |=> $stable(rx_count_reg) && $stable(len_reg))
        else $error("frame state changed without an accepted beat");

endmodule

`default_nettype wire
